// ===== rtl/c3zp_pkg.sv =====
package c3zp_pkg;

  localparam int MAX_WIDTH_DEF = 32;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int FW_W       = 6;
  localparam int COEF_W     = 8;
  localparam int PROD_W     = 17;
  localparam int RES_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int COLX_W   = 7;
  localparam int DIV3_SH  = 7;
  localparam int DIV3_MUL = 43;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  localparam logic [FW_W-1:0]       FRAME_WIDTH_RST  = 6'd6;
  localparam logic [ROW_W-1:0]      FRAME_HEIGHT_RST = 12'd6;
  localparam logic [CFG_DATA_W-1:0] KERNEL_RST       = 24'h0100FF;

  typedef struct packed {
    logic       valid;
    logic       top_ok;
    logic       bot_ok;
    logic       left_ok;
    logic       right_ok;
    logic       last_in_run;
    logic       last_of_frame;
    logic [1:0] bank_top;
    logic [1:0] bank_mid;
    logic [1:0] bank_bot;
  } job_t;

  typedef struct packed {
    logic valid;
    logic last_in_run;
    logic last_of_frame;
  } tag_t;

  typedef struct packed {
    logic [COLX_W-2:0] quot;
    logic [1:0]        rem;
  } div3_t;

  function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[1:0];
  endfunction

  function automatic logic [1:0] mod3_row(input logic [ROW_W-1:0] x);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < ROW_W / 2; i++) begin
      s = s + 5'(x[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  function automatic div3_t div3(input logic [COLX_W-1:0] x);
    logic [2*COLX_W-1:0] p;
    logic [COLX_W-1:0]   t;
    div3_t               d;
    p = (2*COLX_W)'(x) * (2*COLX_W)'(DIV3_MUL);
    d.quot = p[DIV3_SH +: COLX_W-1];
    t = x - {1'b0, d.quot} - {d.quot, 1'b0};
    d.rem = t[1:0];
    return d;
  endfunction

endpackage

// ===== rtl/c3zp_seq.sv =====
module c3zp_seq import c3zp_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] pixel,
  input  logic [FW_W-1:0]  frame_width,
  input  logic [ROW_W-1:0] frame_height,
  output job_t             job,
  output logic [ROW_W-1:0] job_row,
  output logic [COL_W-1:0] job_col,
  output logic             wr_en,
  output logic [1:0]       wr_bank,
  output logic [COL_W-1:0] wr_col,
  output logic [PIX_W-1:0] wr_pixel
);

  logic [ROW_W-1:0] row_counter;
  logic [ROW_W-1:0] r_q;
  logic [ROW_W-1:0] row_last;
  logic [ROW_W-1:0] r_cur;
  logic [COL_W-1:0] col_counter;
  logic [COL_W-1:0] c_q;
  logic [COL_W-1:0] wlast_q;
  logic [COL_W-1:0] fcol;
  logic [COL_W-1:0] w_last;
  logic [COL_W-1:0] c_cur;
  logic [1:0]       rb_q;
  logic [1:0]       rb_cur;
  logic             a_pend;
  logic             b_pend;
  logic             f_pend;
  logic             any_pend;
  logic             take;

  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if ({1'b0, frame_width} > 7'(MAX_WIDTH)) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(frame_width - 6'd1);
    end
    row_last = (frame_height == '0) ? '0 : frame_height - 12'd1;
    r_cur    = (row_counter > row_last) ? row_last : row_counter;
    c_cur    = (col_counter > w_last) ? w_last : col_counter;
    rb_cur   = mod3_row(r_cur);
  end

  always_comb begin
    any_pend = a_pend || b_pend || f_pend;
    job      = '0;
    job_row  = r_q;
    job_col  = fcol;
    if (a_pend || b_pend) begin
      job_row          = r_q - ROW_W'(1);
      job_col          = a_pend ? c_q - COL_W'(1) : wlast_q;
      job.top_ok       = (r_q != ROW_W'(1));
      job.bot_ok       = 1'b1;
      job.bank_top     = mod3_add(rb_q, 2'd1);
      job.bank_mid     = mod3_add(rb_q, 2'd2);
      job.bank_bot     = rb_q;
      job.last_in_run  = a_pend ? !b_pend && !f_pend : !f_pend;
    end else begin
      job.top_ok        = (r_q != '0);
      job.bank_top      = mod3_add(rb_q, 2'd2);
      job.bank_mid      = rb_q;
      job.bank_bot      = rb_q;
      job.last_in_run   = (fcol == wlast_q);
      job.last_of_frame = (fcol == wlast_q);
    end
    job.valid    = any_pend;
    job.left_ok  = (job_col != '0);
    job.right_ok = (job_col != wlast_q);
  end

  assign in_stall = !(advance && (!any_pend || job.last_in_run));
  assign take     = in_valid && !in_stall;
  assign wr_en    = take;
  assign wr_bank  = rb_cur;
  assign wr_col   = c_cur;
  assign wr_pixel = pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
      a_pend      <= 1'b0;
      b_pend      <= 1'b0;
      f_pend      <= 1'b0;
    end else begin
      if (advance && any_pend) begin
        if (a_pend) begin
          a_pend <= 1'b0;
        end else if (b_pend) begin
          b_pend <= 1'b0;
        end else if (fcol == wlast_q) begin
          f_pend <= 1'b0;
        end
      end
      if (take) begin
        a_pend <= (r_cur != '0) && (c_cur != '0);
        b_pend <= (r_cur != '0) && (c_cur == w_last);
        f_pend <= (c_cur == w_last) && (r_cur == row_last);
        if (c_cur == w_last) begin
          col_counter <= '0;
          row_counter <= (r_cur == row_last) ? '0 : r_cur + 12'd1;
        end else begin
          col_counter <= c_cur + COL_W'(1);
          row_counter <= r_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      r_q     <= r_cur;
      c_q     <= c_cur;
      wlast_q <= w_last;
      rb_q    <= rb_cur;
      fcol    <= '0;
    end else if (advance && f_pend && !a_pend && !b_pend && fcol != wlast_q) begin
      fcol <= fcol + COL_W'(1);
    end
  end

endmodule

// ===== rtl/c3zp_window.sv =====
module c3zp_window import c3zp_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        wr_en,
  input  logic [1:0]                  wr_bank,
  input  logic [COL_W-1:0]            wr_col,
  input  logic [PIX_W-1:0]            wr_pixel,
  input  job_t                        job,
  input  logic [ROW_W-1:0]            job_row,
  input  logic [COL_W-1:0]            job_col,
  output tag_t                        tag,
  output logic [ROW_W-1:0]            tag_row,
  output logic [COL_W-1:0]            tag_col,
  output logic [2:0][2:0][PIX_W-1:0]  win
);

  localparam int BANK_D  = (MAX_WIDTH + 2) / 3;
  localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;

  logic [PIX_W-1:0]   store [3][3][BANK_D];
  logic [PIX_W-1:0]   rd_q [3][3];
  logic [1:0]         rowsel_q [3];
  logic [1:0]         rem_q [3];
  logic [2:0]         row_ok_q;
  logic [2:0]         col_ok_q;
  div3_t              wd;
  div3_t              d [3];
  logic [BANK_AW-1:0] addr [3];

  always_comb begin
    wd   = div3(COLX_W'(wr_col));
    d[0] = div3(COLX_W'(job_col) - COLX_W'(1));
    d[1] = div3(COLX_W'(job_col));
    d[2] = div3(COLX_W'(job_col) + COLX_W'(1));
    for (int b = 0; b < 3; b++) begin
      if (d[1].rem == 2'(b)) begin
        addr[b] = d[1].quot[BANK_AW-1:0];
      end else if (d[2].rem == 2'(b)) begin
        addr[b] = d[2].quot[BANK_AW-1:0];
      end else begin
        addr[b] = d[0].quot[BANK_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_bank][wd.rem][wd.quot[BANK_AW-1:0]] <= wr_pixel;
    end
    if (advance) begin
      for (int rb = 0; rb < 3; rb++) begin
        for (int b = 0; b < 3; b++) begin
          rd_q[rb][b] <= store[rb][b][addr[b]];
        end
      end
      rowsel_q[0]       <= job.bank_top;
      rowsel_q[1]       <= job.bank_mid;
      rowsel_q[2]       <= job.bank_bot;
      for (int kj = 0; kj < 3; kj++) begin
        rem_q[kj] <= d[kj].rem;
      end
      row_ok_q          <= {job.bot_ok, 1'b1, job.top_ok};
      col_ok_q          <= {job.right_ok, 1'b1, job.left_ok};
      tag.last_in_run   <= job.last_in_run;
      tag.last_of_frame <= job.last_of_frame;
      tag_row           <= job_row;
      tag_col           <= job_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (advance) begin
      tag.valid <= job.valid;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int kj = 0; kj < 3; kj++) begin
        win[k][kj] = (row_ok_q[k] && col_ok_q[kj]) ? rd_q[rowsel_q[k]][rem_q[kj]] : '0;
      end
    end
  end

endmodule

// ===== rtl/c3zp_mac.sv =====
module c3zp_mac import c3zp_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  tag_t                          tag_in,
  input  logic [ROW_W-1:0]              row_in,
  input  logic [COL_W-1:0]              col_in,
  input  logic [2:0][2:0][PIX_W-1:0]    win,
  input  logic [2:0][CFG_DATA_W-1:0]    kernel,
  output tag_t                          res_tag,
  output logic signed [RES_W-1:0]       result_value,
  output logic [ROW_W-1:0]              out_row,
  output logic [COL_W-1:0]              out_col
);

  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [RES_W-1:0]  rsum_q [3];
  tag_t                     tag1;
  tag_t                     tag2;
  logic [ROW_W-1:0]         row1;
  logic [ROW_W-1:0]         row2;
  logic [COL_W-1:0]         col1;
  logic [COL_W-1:0]         col2;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        for (int kj = 0; kj < 3; kj++) begin
          prod_q[k][kj] <= $signed({1'b0, win[k][kj]})
                         * $signed(kernel[k][COEF_W*kj +: COEF_W]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        rsum_q[k] <= RES_W'(prod_q[k][0]) + RES_W'(prod_q[k][1]) + RES_W'(prod_q[k][2]);
      end
      result_value          <= rsum_q[0] + rsum_q[1] + rsum_q[2];
      tag1.last_in_run      <= tag_in.last_in_run;
      tag1.last_of_frame    <= tag_in.last_of_frame;
      tag2.last_in_run      <= tag1.last_in_run;
      tag2.last_of_frame    <= tag1.last_of_frame;
      res_tag.last_in_run   <= tag2.last_in_run;
      res_tag.last_of_frame <= tag2.last_of_frame;
      row1                  <= row_in;
      row2                  <= row1;
      out_row               <= row2;
      col1                  <= col_in;
      col2                  <= col1;
      out_col               <= col2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid    <= 1'b0;
      tag2.valid    <= 1'b0;
      res_tag.valid <= 1'b0;
    end else if (advance) begin
      tag1.valid    <= tag_in.valid;
      tag2.valid    <= tag1.valid;
      res_tag.valid <= tag2.valid;
    end
  end

endmodule

// ===== rtl/conv3x3_zero_pad_stream.sv =====
// 3x3 zero-padded convolution over a raster pixel stream.
// Input beats carry one 8-bit pixel each, in raster order, on in_valid/in_stall.
// Output beats carry one window sum with its center row and column on
// out_valid/out_stall; last_in_run marks the final beat caused by a pixel and
// last_of_frame the bottom-right output of the frame.
// Registers (frame size, three kernel rows) are written on cfg_valid/cfg_ready,
// always ready; write them only while no results are outstanding.
// Outputs pass the sequencer job, window read and MAC product, row-sum and
// result registers. One beat per cycle while out_stall is low; a pixel with n
// outputs uses the shared read and multiply path once each (n is 2 at a row
// end past row 0, up to width+2 at frame end); the next pixel waits for them.
// Pixels outside the frame count as zero, so output size equals frame size.
// Reset clears row and column counters and loads a 6x6 frame with kernel
// rows {-1, 0, 1}. The line store needs no clearing.
// While a result beat waits under out_stall the whole pipeline holds and
// in_stall rises.
module conv3x3_zero_pad_stream import c3zp_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PIX_W-1:0]       pixel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [RES_W-1:0] result_value,
  output logic [ROW_W-1:0]       out_row,
  output logic [COL_W-1:0]       out_col,
  output logic                   last_in_run,
  output logic                   last_of_frame,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [FW_W-1:0]                 frame_width;
  logic [ROW_W-1:0]                frame_height;
  logic [2:0][CFG_DATA_W-1:0]      kernel;
  logic                            advance;
  job_t                            job;
  logic [ROW_W-1:0]                job_row;
  logic [COL_W-1:0]                job_col;
  logic                            wr_en;
  logic [1:0]                      wr_bank;
  logic [COL_W-1:0]                wr_col;
  logic [PIX_W-1:0]                wr_pixel;
  tag_t                            win_tag;
  logic [ROW_W-1:0]                win_row;
  logic [COL_W-1:0]                win_col;
  logic [2:0][2:0][PIX_W-1:0]      win;
  tag_t                            res_tag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      kernel[0]    <= KERNEL_RST;
      kernel[1]    <= KERNEL_RST;
      kernel[2]    <= KERNEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT:  frame_height <= cfg_data[ROW_W-1:0];
        REG_KERNEL_TOP:    kernel[0]    <= cfg_data;
        REG_KERNEL_MID:    kernel[1]    <= cfg_data;
        REG_KERNEL_BOTTOM: kernel[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold every stage while a finished beat waits at the output
  assign advance = !res_tag.valid || !out_stall;

  c3zp_seq #(.MAX_WIDTH(MAX_WIDTH)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel        (pixel),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .job          (job),
    .job_row      (job_row),
    .job_col      (job_col),
    .wr_en        (wr_en),
    .wr_bank      (wr_bank),
    .wr_col       (wr_col),
    .wr_pixel     (wr_pixel)
  );

  c3zp_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .wr_en    (wr_en),
    .wr_bank  (wr_bank),
    .wr_col   (wr_col),
    .wr_pixel (wr_pixel),
    .job      (job),
    .job_row  (job_row),
    .job_col  (job_col),
    .tag      (win_tag),
    .tag_row  (win_row),
    .tag_col  (win_col),
    .win      (win)
  );

  c3zp_mac #(.MAX_WIDTH(MAX_WIDTH)) u_mac (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .tag_in       (win_tag),
    .row_in       (win_row),
    .col_in       (win_col),
    .win          (win),
    .kernel       (kernel),
    .res_tag      (res_tag),
    .result_value (result_value),
    .out_row      (out_row),
    .out_col      (out_col)
  );

  assign out_valid     = res_tag.valid;
  assign last_in_run   = res_tag.last_in_run;
  assign last_of_frame = res_tag.last_of_frame;

endmodule
